FILE: rtl/rns_crt_constant_engine_top_macros.svh
// Assertion macros for the RNS CRT constant engine.
`ifndef RNS_CRT_CONSTANT_ENGINE_TOP_MACROS_SVH
`define RNS_CRT_CONSTANT_ENGINE_TOP_MACROS_SVH
`ifndef SYNTH
`define RCE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RCE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RCE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RCE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/rce_pkg.sv
// Package: constants, codes and state type of the RNS CRT constant engine.
`timescale 1ns / 1ps
package rce_pkg;
  localparam int MAX_P = 8;
  localparam int MAX_Q = 32;
  localparam int MOD_BITS = 60;
  localparam int PI_W = $clog2(MAX_P);
  localparam int QI_W = $clog2(MAX_Q);
  localparam int BIT_W = 7;
  localparam int DW = MOD_BITS + 2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INDEX = 2'd1;
  localparam logic [1:0] ST_NOINV = 2'd2;
  localparam logic [1:0] ST_SMALL = 2'd3;

  localparam logic [2:0] K_INV_PHAT_P = 3'd0;
  localparam logic [2:0] K_PHAT_Q = 3'd1;
  localparam logic [2:0] K_INVP_Q = 3'd2;
  localparam logic [2:0] K_INV_QHAT_Q = 3'd3;
  localparam logic [2:0] K_QHAT_P = 3'd4;

  localparam logic [0:0] A_LOAD = 1'b0;
  localparam logic [0:0] REG_PCOUNT = 1'b0;
  localparam logic [0:0] REG_QCOUNT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH_M, S_LATCH_M, S_FETCH_F, S_REDUCE, S_MUL,
    S_INV_TEST, S_DIV, S_TMUL, S_TWAIT, S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
  } mul_req_t;
endpackage

FILE: rtl/rce_modmul.sv
// Bit-serial modular multiplier: one bit of b per cycle, acc = 2acc (+a) mod m.
`timescale 1ns / 1ps
module rce_modmul (
  input  logic clk,
  input  logic rst_n,
  input  rce_pkg::mul_req_t req,
  input  logic [rce_pkg::DW-1:0] m,
  output logic busy,
  output logic [rce_pkg::DW-1:0] res
);
  import rce_pkg::*;
  logic [DW-1:0] acc_r, acc_nxt, b_r, b_nxt, a_r;
  logic [BIT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [DW:0] dbl, dred, sum;

  always_comb begin
    dbl = {acc_r, 1'b0};
    dred = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum = dred + (b_r[DW-1] ? {1'b0, a_r} : '0);
    if (sum >= {1'b0, m}) sum = sum - {1'b0, m};
    acc_nxt = acc_r;
    b_nxt = b_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      acc_nxt = '0;
      b_nxt = req.b;
      cnt_nxt = BIT_W'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = sum[DW-1:0];
      b_nxt = {b_r[DW-2:0], 1'b0};
      cnt_nxt = cnt_r - BIT_W'(1);
      busy_nxt = (cnt_r != BIT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    b_r <= b_nxt;
    if (req.start) a_r <= req.a;
  end

  assign busy = busy_r;
  assign res = acc_r;
endmodule

FILE: rtl/rns_crt_constant_engine_top.sv
// Top level of the RNS CRT constant engine: tables, sequencer, shared multiplier.
`timescale 1ns / 1ps
// Timing: a load or a refused query answers in the cycle after acceptance; a query walks
// its table with one serial multiply per factor, skipping the excluded entry.
// An inverse adds up to ~87 Euclid steps, each a serial division and a serial multiply.
// Throughput: one beat at a time; in_ready is low from acceptance to output handoff.
// Reset (rst_n, synchronous): counts return to 1, sequencer idle; tables undefined.
`include "rns_crt_constant_engine_top_macros.svh"
module rns_crt_constant_engine_top (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_action,
  input  logic in_basis_sel,
  input  logic [4:0] in_slot,
  input  logic [59:0] in_modulus,
  input  logic [2:0] in_kind,
  input  logic [4:0] in_level,
  input  logic [4:0] in_q_index,
  input  logic [2:0] in_p_index,
  output logic out_valid,
  input  logic out_ready,
  output logic [59:0] out_value,
  output logic [1:0] out_status,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import rce_pkg::*;

  // The inverse runs the extended Euclidean algorithm: each step divides by
  // shift and subtract, one quotient bit per cycle, and then updates the
  // coefficient mod m with the shared multiplier (t2 = t0 - q*t1 mod m).

  logic [3:0] pcount_r;
  logic [5:0] qcount_r;
  logic [MOD_BITS-1:0] pmem [MAX_P];
  logic [MOD_BITS-1:0] qmem [MAX_Q];
  logic [MOD_BITS-1:0] prd_r, qrd_r;

  state_t state_r, state_nxt;
  logic [5:0] k_r, k_nxt, n_r, skip_r;
  logic walk_p_r, do_inv_r, mod_p_r;
  logic [PI_W-1:0] pi_r;
  logic [QI_W-1:0] qj_r;
  logic [DW-1:0] m_r, m_nxt, acc_r, acc_nxt;
  logic [DW-1:0] r0_r, r0_nxt, r1_r, r1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  logic [DW-1:0] quo_r, quo_nxt, rem_r, rem_nxt;
  logic [DW:0] trial;
  logic [BIT_W-1:0] dcnt_r, dcnt_nxt;
  logic inv_ok_r, inv_ok_nxt;
  logic [59:0] oval_r, oval_nxt;
  logic [1:0] ost_r, ost_nxt;
  logic ovalid_r, ovalid_nxt;
  mul_req_t req;
  logic mbusy;
  logic [DW-1:0] mres;
  logic [PI_W-1:0] prd_addr;
  logic [QI_W-1:0] qrd_addr;
  logic [3:0] np;
  logic [5:0] nq;
  logic in_acc, cfg_wr;

  assign np = (pcount_r > 4'(MAX_P)) ? 4'(MAX_P) : pcount_r;
  assign nq = (qcount_r > 6'(MAX_Q)) ? 6'(MAX_Q) : qcount_r;
  assign in_ready = (state_r == S_IDLE) && !ovalid_r;
  assign in_acc = in_valid && in_ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[2])
      REG_PCOUNT: cfg_prdata = {28'd0, pcount_r};
      default: cfg_prdata = {26'd0, qcount_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r <= 4'd1;
      qcount_r <= 6'd1;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_PCOUNT) pcount_r <= cfg_pwdata[3:0];
      else qcount_r <= cfg_pwdata[5:0];
    end
  end

  // Load path: write on acceptance when slot and value are good.
  always_ff @(posedge clk) begin
    if (in_acc && in_action == A_LOAD && in_modulus >= 60'd2) begin
      if (in_basis_sel && {1'b0, in_slot} < 6'(MAX_Q)) qmem[in_slot[QI_W-1:0]] <= in_modulus;
      if (!in_basis_sel && {1'b0, in_slot} < 6'(MAX_P)) pmem[in_slot[PI_W-1:0]] <= in_modulus;
    end
    prd_r <= pmem[prd_addr];
    qrd_r <= qmem[qrd_addr];
  end

  rce_modmul u_mul (.clk(clk), .rst_n(rst_n), .req(req), .m(m_r), .busy(mbusy),
    .res(mres));

  always_comb begin
    prd_addr = pi_r;
    qrd_addr = qj_r;
    if (state_r == S_FETCH_F || state_r == S_REDUCE) begin
      if (walk_p_r) prd_addr = k_r[PI_W-1:0];
      else qrd_addr = k_r[QI_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    k_r <= k_nxt; m_r <= m_nxt; acc_r <= acc_nxt;
    r0_r <= r0_nxt; r1_r <= r1_nxt; t0_r <= t0_nxt; t1_r <= t1_nxt;
    quo_r <= quo_nxt; rem_r <= rem_nxt; dcnt_r <= dcnt_nxt; inv_ok_r <= inv_ok_nxt;
    oval_r <= oval_nxt; ost_r <= ost_nxt;
    if (in_acc) begin
      pi_r <= in_p_index[PI_W-1:0];
      qj_r <= in_q_index[QI_W-1:0];
      walk_p_r <= (in_kind == K_INV_PHAT_P || in_kind == K_PHAT_Q || in_kind == K_INVP_Q);
      do_inv_r <= (in_kind == K_INV_PHAT_P || in_kind == K_INVP_Q || in_kind == K_INV_QHAT_Q);
      mod_p_r <= (in_kind == K_INV_PHAT_P || in_kind == K_QHAT_P);
      n_r <= (in_kind == K_INV_PHAT_P || in_kind == K_PHAT_Q || in_kind == K_INVP_Q) ?
             {2'd0, np} : {1'b0, in_level} + 6'd1;
      skip_r <= (in_kind == K_INVP_Q) ? 6'd63 :
                (in_kind == K_INV_PHAT_P || in_kind == K_PHAT_Q) ? {3'd0, in_p_index} :
                {1'b0, in_q_index};
    end
  end

  always_comb begin
    logic p_ok, q_ok, l_ok, bad;
    p_ok = {1'b0, in_p_index} < np;
    q_ok = {1'b0, in_q_index} < nq;
    l_ok = ({1'b0, in_level} < nq) && (in_q_index <= in_level);
    unique case (in_kind)
      K_INV_PHAT_P: bad = !p_ok;
      K_PHAT_Q: bad = !p_ok || !q_ok;
      K_INVP_Q: bad = !q_ok;
      K_INV_QHAT_Q: bad = !l_ok;
      K_QHAT_P: bad = !l_ok || !p_ok;
      default: bad = 1'b1;
    endcase
    trial = {rem_r, quo_r[DW-1]};
    state_nxt = state_r;
    k_nxt = k_r; m_nxt = m_r; acc_nxt = acc_r;
    r0_nxt = r0_r; r1_nxt = r1_r; t0_nxt = t0_r; t1_nxt = t1_r;
    quo_nxt = quo_r; rem_nxt = rem_r; dcnt_nxt = dcnt_r; inv_ok_nxt = inv_ok_r;
    oval_nxt = oval_r; ost_nxt = ost_r;
    ovalid_nxt = ovalid_r && !out_ready;
    req = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          oval_nxt = '0;
          if (in_action == A_LOAD) begin
            if ({1'b0, in_slot} >= (in_basis_sel ? 6'(MAX_Q) : 6'(MAX_P))) ost_nxt = ST_INDEX;
            else if (in_modulus < 60'd2) ost_nxt = ST_SMALL;
            else ost_nxt = ST_OK;
            ovalid_nxt = 1'b1;
          end else if (bad) begin
            ost_nxt = ST_INDEX;
            ovalid_nxt = 1'b1;
          end else begin
            ost_nxt = ST_OK;
            state_nxt = S_FETCH_M;
          end
        end
      end
      S_FETCH_M: state_nxt = S_LATCH_M;
      S_LATCH_M: begin
        m_nxt = {2'b0, mod_p_r ? prd_r : qrd_r};
        acc_nxt = DW'(1);
        k_nxt = '0;
        state_nxt = S_FETCH_F;
      end
      S_FETCH_F: begin
        if (k_r >= n_r) begin
          if (m_r < DW'(2)) acc_nxt = '0;
          // seed Euclid: (r0, r1) = (m, x), coefficients (0, 1)
          r0_nxt = m_r;
          r1_nxt = (m_r < DW'(2)) ? '0 : acc_r;
          t0_nxt = '0;
          t1_nxt = DW'(1);
          state_nxt = do_inv_r ? S_INV_TEST : S_DONE;
        end else if (k_r == skip_r) k_nxt = k_r + 6'd1;
        else state_nxt = S_REDUCE;
      end
      S_REDUCE: begin
        // multiply by table entry: acc < m, entry reduced by the serial unit
        req.start = 1'b1;
        req.a = acc_r;
        req.b = {2'b0, walk_p_r ? prd_r : qrd_r};
        state_nxt = S_MUL;
      end
      S_MUL: if (!mbusy) begin
        acc_nxt = (m_r == '0) ? '0 : mres;
        k_nxt = k_r + 6'd1;
        state_nxt = S_FETCH_F;
      end
      S_INV_TEST: begin
        if (r1_r == '0) begin
          // gcd must be 1; the last coefficient is the inverse mod m
          inv_ok_nxt = (r0_r == DW'(1)) && (m_r >= DW'(2));
          acc_nxt = t0_r;
          state_nxt = S_DONE;
        end else begin
          quo_nxt = r0_r;
          rem_nxt = '0;
          dcnt_nxt = BIT_W'(DW);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // one restoring step: shift in the next dividend bit, subtract if it fits
        if (trial >= {1'b0, r1_r}) begin
          rem_nxt = DW'(trial - {1'b0, r1_r});
          quo_nxt = {quo_r[DW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DW-1:0];
          quo_nxt = {quo_r[DW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - BIT_W'(1);
        if (dcnt_r == BIT_W'(1)) state_nxt = S_TMUL;
      end
      S_TMUL: begin
        req.start = 1'b1;
        req.a = t1_r;
        req.b = quo_r;
        state_nxt = S_TWAIT;
      end
      S_TWAIT: if (!mbusy) begin
        t1_nxt = (t0_r >= mres) ? t0_r - mres : t0_r + (m_r - mres);
        t0_nxt = t1_r;
        r0_nxt = r1_r;
        r1_nxt = rem_r;
        state_nxt = S_INV_TEST;
      end
      S_DONE: begin
        oval_nxt = acc_r[MOD_BITS-1:0];
        if (do_inv_r && !inv_ok_r) begin
          ost_nxt = ST_NOINV;
          oval_nxt = '0;
        end
        ovalid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = ovalid_r;
  assign out_value = oval_r;
  assign out_status = ost_r;

  `RCE_ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_r != S_IDLE, !in_ready)
  `RCE_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_status != ST_OK, out_value == '0)
  `RCE_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value))
endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the RNS CRT constant engine top level.
`timescale 1ns / 1ps
module testbench;
  import rce_pkg::*;

  localparam logic [0:0] A_QUERY = 1'b1;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int LONG_HOLD = 600;

  typedef struct {
    logic action;
    logic basis_sel;
    logic [4:0] slot;
    logic [59:0] modulus;
    logic [2:0] kind;
    logic [4:0] level;
    logic [4:0] q_index;
    logic [2:0] p_index;
  } beat_t;

  typedef struct {
    logic [59:0] value;
    logic [1:0] status;
  } constant_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic in_action, in_basis_sel;
  logic [4:0] in_slot, in_level, in_q_index;
  logic [59:0] in_modulus;
  logic [2:0] in_kind, in_p_index;
  logic out_valid, out_ready;
  logic [59:0] out_value;
  logic [1:0] out_status;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  rns_crt_constant_engine_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_basis_sel(in_basis_sel), .in_slot(in_slot),
    .in_modulus(in_modulus), .in_kind(in_kind), .in_level(in_level),
    .in_q_index(in_q_index), .in_p_index(in_p_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_status(out_status),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Clock: 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor state: shadow tables and count registers.
  logic [59:0] p_table [MAX_P];
  logic [59:0] q_table [MAX_Q];
  int p_count_reg = 1;
  int q_count_reg = 1;

  beat_t pending_beats [$];
  constant_t expected_constants [$];

  bit quiet = 1'b0;        // no idling on either side in the last phase
  bit beat_taken = 1'b0;   // set at the edge that accepts an input beat
  int gap_cycles = 0;
  int stall_cycles = 0;
  int accepted_beats = 0;
  bit long_hold_done = 1'b0;
  int mismatches = 0;
  int idle_count = 0;

  // (a * b) mod m on 128-bit intermediates.
  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] prod;
    if (m == 0) return 64'd0;
    prod = {64'd0, a % m};
    prod = prod * {64'd0, b % m};
    return 64'(prod % {64'd0, m});
  endfunction

  // Exact inverse by the extended Euclidean algorithm; returns 0 if none.
  function automatic bit inv_mod(logic [63:0] a, logic [63:0] m, output logic [63:0] r);
    longint t0 = 0;
    longint t1 = 1;
    longint t2;
    logic [63:0] r0, r1, r2, qt;
    r = 64'd0;
    if (m < 2) return 1'b0;
    r0 = m;
    r1 = a % m;
    while (r1 != 0) begin
      qt = r0 / r1;
      r2 = r0 - qt * r1;
      t2 = t0 - longint'(qt) * t1;
      r0 = r1;
      r1 = r2;
      t0 = t1;
      t1 = t2;
    end
    if (r0 != 1) return 1'b0;
    if (t0 < 0) t0 += longint'(m);
    r = t0;
    return 1'b1;
  endfunction

  // Product of p entries 0..n-1 except skip, mod m.
  function automatic logic [63:0] p_prod_mod(int n, int skip, logic [63:0] m);
    logic [63:0] acc;
    acc = (m < 2) ? 64'd0 : 64'd1;
    for (int k = 0; k < n && k < MAX_P; k++)
      if (k != skip) acc = mul_mod(acc, {4'd0, p_table[k]}, m);
    return acc;
  endfunction

  function automatic logic [63:0] q_prod_mod(int n, int skip, logic [63:0] m);
    logic [63:0] acc;
    acc = (m < 2) ? 64'd0 : 64'd1;
    for (int k = 0; k < n && k < MAX_Q; k++)
      if (k != skip) acc = mul_mod(acc, {4'd0, q_table[k]}, m);
    return acc;
  endfunction

  // Compute the constant a beat yields and apply any table write.
  function automatic constant_t crt_constant(beat_t b);
    constant_t c;
    int np, nq, i, j, lvl, lim;
    bit p_ok, q_ok, l_ok;
    logic [63:0] x, v;
    np = (p_count_reg > MAX_P) ? MAX_P : p_count_reg;
    nq = (q_count_reg > MAX_Q) ? MAX_Q : q_count_reg;
    i = b.p_index;
    j = b.q_index;
    lvl = b.level;
    c.value = '0;
    c.status = ST_OK;
    v = 64'd0;
    if (b.action == A_LOAD) begin
      lim = b.basis_sel ? MAX_Q : MAX_P;
      if (b.slot >= lim) c.status = ST_INDEX;
      else if (b.modulus < 2) c.status = ST_SMALL;
      else if (b.basis_sel) q_table[b.slot] = b.modulus;
      else p_table[b.slot] = b.modulus;
      return c;
    end
    p_ok = i < np;
    q_ok = j < nq;
    l_ok = (lvl < nq) && (j <= lvl);
    case (b.kind)
      K_INV_PHAT_P: begin
        if (!p_ok) c.status = ST_INDEX;
        else begin
          x = p_prod_mod(np, i, {4'd0, p_table[i]});
          if (!inv_mod(x, {4'd0, p_table[i]}, v)) c.status = ST_NOINV;
        end
      end
      K_PHAT_Q: begin
        if (!p_ok || !q_ok) c.status = ST_INDEX;
        else v = p_prod_mod(np, i, {4'd0, q_table[j]});
      end
      K_INVP_Q: begin
        if (!q_ok) c.status = ST_INDEX;
        else begin
          x = p_prod_mod(np, MAX_P, {4'd0, q_table[j]});
          if (!inv_mod(x, {4'd0, q_table[j]}, v)) c.status = ST_NOINV;
        end
      end
      K_INV_QHAT_Q: begin
        if (!l_ok) c.status = ST_INDEX;
        else begin
          x = q_prod_mod(lvl + 1, j, {4'd0, q_table[j]});
          if (!inv_mod(x, {4'd0, q_table[j]}, v)) c.status = ST_NOINV;
        end
      end
      K_QHAT_P: begin
        if (!l_ok || !p_ok) c.status = ST_INDEX;
        else v = q_prod_mod(lvl + 1, j, {4'd0, p_table[i]});
      end
      default: c.status = ST_INDEX;
    endcase
    if (c.status != ST_OK) v = 64'd0;
    c.value = v[59:0];
    return c;
  endfunction

  // Driver: present beats at the falling edge, hold them until accepted.
  always @(negedge clk) begin
    beat_t b;
    logic nxt_valid;
    nxt_valid = in_valid;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (!in_valid || beat_taken) begin
      nxt_valid = 1'b0;
      if (gap_cycles > 0) begin
        gap_cycles--;
      end else if (pending_beats.size() > 0) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          gap_cycles = $urandom_range(0, 14);
        end else begin
          b = pending_beats.pop_front();
          in_action <= b.action;
          in_basis_sel <= b.basis_sel;
          in_slot <= b.slot;
          in_modulus <= b.modulus;
          in_kind <= b.kind;
          in_level <= b.level;
          in_q_index <= b.q_index;
          in_p_index <= b.p_index;
          nxt_valid = 1'b1;
        end
      end
    end
    beat_taken = 1'b0;
    in_valid <= nxt_valid;
  end

  // Receiver: random stall bursts plus one long hold-off to back up the input.
  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (!long_hold_done && accepted_beats >= 300) begin
      long_hold_done = 1'b1;
      stall_cycles = LONG_HOLD;
    end
    if (stall_cycles > 0) begin
      stall_cycles--;
      nxt_ready = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_cycles = $urandom_range(0, 14);
      nxt_ready = 1'b0;
    end
    out_ready <= nxt_ready;
  end

  // Monitor: predict at input acceptance, check at output acceptance.
  always @(posedge clk) begin
    beat_t b;
    constant_t exp_c;
    if (rst_n) begin
      idle_count++;
      if (in_valid && in_ready) begin
        b.action = in_action;
        b.basis_sel = in_basis_sel;
        b.slot = in_slot;
        b.modulus = in_modulus;
        b.kind = in_kind;
        b.level = in_level;
        b.q_index = in_q_index;
        b.p_index = in_p_index;
        expected_constants.insert(expected_constants.size(), crt_constant(b));
        beat_taken = 1'b1;
        accepted_beats++;
        idle_count = 0;
      end
      if (out_valid && out_ready) begin
        idle_count = 0;
        if (expected_constants.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value=%h status=%0d", out_value, out_status);
        end else begin
          exp_c = expected_constants.pop_front();
          if (out_value !== exp_c.value || out_status !== exp_c.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                       exp_c.value, exp_c.status, out_value, out_status);
          end
        end
      end
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic logic [59:0] pick_modulus();
    case ($urandom_range(0, 9))
      0: return 60'($urandom_range(2, 1000));
      1: return {60{1'b1}};
      2: return 60'($urandom_range(0, 1));
      3: return {1'b1, 27'd0, 32'($urandom)};
      default: return {28'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Every beat carries random junk in the fields its action ignores.
  function automatic beat_t random_beat();
    beat_t b;
    b.action = 1'($urandom);
    b.basis_sel = 1'($urandom);
    b.slot = 5'($urandom);
    b.modulus = {28'($urandom), 32'($urandom)};
    b.kind = 3'($urandom);
    b.level = 5'($urandom);
    b.q_index = 5'($urandom);
    b.p_index = 3'($urandom);
    return b;
  endfunction

  task automatic push_load(logic sel, logic [4:0] slot, logic [59:0] m);
    beat_t b;
    b = random_beat();
    b.action = A_LOAD;
    b.basis_sel = sel;
    b.slot = slot;
    b.modulus = m;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  task automatic push_query(logic [2:0] kind, logic [4:0] lvl, logic [4:0] j, logic [2:0] i);
    beat_t b;
    b = random_beat();
    b.action = A_QUERY;
    b.kind = kind;
    b.level = lvl;
    b.q_index = j;
    b.p_index = i;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  // Random traffic: mostly in-range queries at small levels, some loads and noise.
  task automatic push_random(int n);
    int np, nq, lvl;
    np = (p_count_reg > MAX_P) ? MAX_P : p_count_reg;
    nq = (q_count_reg > MAX_Q) ? MAX_Q : q_count_reg;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1: push_load(1'($urandom), 5'($urandom), pick_modulus());
        2: pending_beats.insert(pending_beats.size(), random_beat());
        default: begin
          if (nq == 0) lvl = $urandom_range(0, 31);
          else if ($urandom_range(0, 4) == 0) lvl = $urandom_range(0, nq - 1);
          else lvl = $urandom_range(0, (nq > 8 ? 8 : nq) - 1);
          push_query(3'($urandom_range(0, 4)), 5'(lvl),
                     5'($urandom_range(0, lvl)),
                     3'($urandom_range(0, np > 0 ? np - 1 : 7)));
        end
      endcase
    end
  endtask

  // Hold the sender until every expected result has come.
  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || expected_constants.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(logic [0:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 3'(4 * idx);
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_PCOUNT) p_count_reg = data[3:0];
    else q_count_reg = data[5:0];
  endtask

  task automatic set_counts(int np, int nq);
    cfg_write(REG_PCOUNT, 32'(np));
    cfg_write(REG_QCOUNT, 32'(nq));
  endtask

  initial begin
    in_valid = 1'b0;
    in_action = 1'b0;
    in_basis_sel = 1'b0;
    in_slot = '0;
    in_modulus = '0;
    in_kind = '0;
    in_level = '0;
    in_q_index = '0;
    in_p_index = '0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill both tables first so no query ever reads an unwritten entry.
    for (int k = 0; k < MAX_P; k++) push_load(1'b0, 5'(k), pick_modulus() | 60'd2);
    for (int k = 0; k < MAX_Q; k++) push_load(1'b1, 5'(k), pick_modulus() | 60'd2);
    push_query(K_INV_PHAT_P, 0, 0, 0);
    push_query(K_INV_QHAT_Q, 0, 0, 0);
    drain();

    // Directed: extremes, every kind, bad indexes, shared factors.
    set_counts(8, 32);
    push_load(1'b0, 5'd8, 60'd97);
    push_load(1'b1, 5'd31, {60{1'b1}});
    push_load(1'b0, 5'd3, 60'd0);
    push_load(1'b1, 5'd4, 60'd1);
    push_load(1'b0, 5'd0, 60'd1000003);
    push_load(1'b1, 5'd0, 60'd1000003);
    push_load(1'b0, 5'd1, 60'd6);
    push_load(1'b0, 5'd2, 60'd9);
    push_query(K_INVP_Q, 0, 0, 0);
    push_query(K_INV_PHAT_P, 0, 0, 1);
    push_query(K_INV_PHAT_P, 0, 0, 7);
    push_query(K_PHAT_Q, 0, 31, 7);
    push_query(K_INVP_Q, 0, 31, 0);
    push_query(K_INV_QHAT_Q, 31, 31, 0);
    push_query(K_INV_QHAT_Q, 5, 6, 0);
    push_query(K_QHAT_P, 31, 0, 7);
    push_query(3'd5, 0, 0, 0);
    push_query(3'd6, 0, 0, 0);
    push_query(3'd7, 0, 0, 0);
    drain();

    set_counts(0, 0);
    push_query(K_INV_PHAT_P, 0, 0, 0);
    push_query(K_PHAT_Q, 0, 0, 0);
    push_query(K_INVP_Q, 0, 0, 0);
    push_query(K_QHAT_P, 0, 0, 0);
    push_random(20);
    drain();

    set_counts(15, 63);
    push_random(100);
    drain();
    set_counts(1, 1);
    push_random(100);
    drain();

    // Random settings; the long receiver hold-off falls in here.
    for (int ph = 0; ph < 4; ph++) begin
      set_counts($urandom_range(0, 15), $urandom_range(0, 63));
      push_random(100);
      drain();
    end

    // Last phase: no idling anywhere.
    set_counts(8, $urandom_range(1, 32));
    quiet = 1'b1;
    push_random(60);
    drain();
    repeat (100) @(posedge clk);

    if (mismatches == 0 && expected_constants.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/rce_pkg.sv
rtl/rce_modmul.sv
rtl/rns_crt_constant_engine_top.sv
tb/sv/testbench.sv
